### rtl/core/twrtc_pkg.sv
package twrtc_pkg;

    localparam int BURST_BYTES_DEFAULT = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int LANES = 8;

    localparam logic [7:0] BURST_READ_RESET = 8'd191;
    localparam logic [7:0] BURST_WRITE_RESET = 8'd190;
    localparam logic [7:0] PROTECT_RESET = 8'd142;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_CLEAR_WP = 2'd2,
        OP_INVALID  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_BURST_READ  = 2'd0,
        CFG_BURST_WRITE = 2'd1,
        CFG_PROTECT     = 2'd2,
        CFG_NONE        = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef struct packed {
        logic        start_ok;
        t_opcode     opcode;
        logic [7:0]  command;
        logic        burst;
        logic [63:0] write_bcd;
        logic        io_in;
    } t_item;

    typedef struct packed {
        logic        chip_enable;
        logic        serial_clock;
        logic        io_out;
        logic        io_drive;
        logic        busy_res;
        logic        done_res;
        logic [63:0] read_bytes;
    } t_result;

    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  tens;
        logic [7:0]  ones;
        prod = {8'b0, v} * 16'd205;
        tens = prod[15:11];
        ones = v - ({3'b0, tens} * 8'd10);
        return {tens[3:0], 4'b0} | ones;
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        return ({4'b0, v[7:4]} * 8'd10) + {4'b0, v[3:0]};
    endfunction

endpackage

### rtl/core/twrtc_front.sv
module twrtc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_start_req,
    input  logic [1:0]           i_opcode,
    input  logic [7:0]           i_command,
    input  logic [63:0]          i_write_bytes,
    input  logic                 i_io_in,
    output twrtc_pkg::t_item     o_item
);
    import twrtc_pkg::*;

    logic [7:0] r_burst_read;
    logic [7:0] r_burst_write;
    logic [7:0] r_protect;
    t_opcode    op;
    logic [63:0] bcd_all;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_read  <= BURST_READ_RESET;
            r_burst_write <= BURST_WRITE_RESET;
            r_protect     <= PROTECT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_BURST_READ:  r_burst_read  <= i_cfg_data;
                CFG_BURST_WRITE: r_burst_write <= i_cfg_data;
                CFG_PROTECT:     r_protect     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign op = t_opcode'(i_opcode);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            bcd_all[8*k +: 8] = to_bcd(i_write_bytes[8*k +: 8]);
        end
    end

    always_comb begin
        o_item.start_ok = i_start_req && (op != OP_INVALID);
        o_item.opcode   = op;
        o_item.io_in    = i_io_in;
        unique case (op)
            OP_READ: begin
                o_item.command   = i_command;
                o_item.burst     = (i_command == r_burst_read);
                o_item.write_bcd = bcd_all;
            end
            OP_WRITE: begin
                o_item.command   = i_command;
                o_item.burst     = (i_command == r_burst_write);
                o_item.write_bcd = bcd_all;
            end
            OP_CLEAR_WP: begin
                o_item.command   = r_protect;
                o_item.burst     = 1'b0;
                o_item.write_bcd = '0;
            end
            default: begin
                o_item.command   = i_command;
                o_item.burst     = 1'b0;
                o_item.write_bcd = '0;
            end
        endcase
    end

endmodule

### rtl/core/twrtc_queue.sv
module twrtc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  twrtc_pkg::t_item     i_item,
    output logic                 o_not_full,
    input  logic                 i_pop,
    output logic                 o_not_empty,
    output twrtc_pkg::t_item     o_item
);
    import twrtc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;

    assign o_not_full  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/core/twrtc_back.sv
module twrtc_back #(
    parameter int BURST_BYTES = twrtc_pkg::BURST_BYTES_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  twrtc_pkg::t_item     i_item,
    output logic                 o_item_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output twrtc_pkg::t_result   o_result
);
    import twrtc_pkg::*;

    t_phase      r_phase,        n_phase;
    logic        r_half,         n_half;
    logic [2:0]  r_bit_index,    n_bit_index;
    logic [3:0]  r_byte_index,   n_byte_index;
    logic [7:0]  r_shift,        n_shift;
    logic [7:0]  r_held_command, n_held_command;
    t_opcode     r_held_opcode,  n_held_opcode;
    logic        r_burst,        n_burst;
    logic [63:0] r_held_bcd,     n_held_bcd;
    logic [63:0] r_read_buffer,  n_read_buffer;
    logic        r_out_valid;
    t_result     r_out;
    t_result     pins;
    logic        fire;
    logic [3:0]  byte_count;
    logic [3:0]  next_byte;
    logic [2:0]  cur_lane;
    logic [2:0]  next_lane;
    logic [2:0]  single_lane;

    assign fire       = i_item_valid && (!r_out_valid || i_ready);
    assign o_item_pop = fire;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    assign byte_count  = r_burst ? 4'(BURST_BYTES) : 4'd1;
    assign next_byte   = r_byte_index + 4'd1;
    assign single_lane = (r_held_opcode == OP_WRITE) ? r_held_command[3:1] : 3'd0;
    assign cur_lane    = r_burst ? r_byte_index[2:0] : single_lane;
    assign next_lane   = r_burst ? next_byte[2:0] : single_lane;

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_half         = r_half;
        n_bit_index    = r_bit_index;
        n_byte_index   = r_byte_index;
        n_shift        = r_shift;
        n_held_command = r_held_command;
        n_held_opcode  = r_held_opcode;
        n_burst        = r_burst;
        n_held_bcd     = r_held_bcd;
        n_read_buffer  = r_read_buffer;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.start_ok) begin
                    n_held_opcode  = i_item.opcode;
                    n_held_command = i_item.command;
                    n_burst        = i_item.burst;
                    n_held_bcd     = i_item.write_bcd;
                    n_half         = 1'b0;
                    n_bit_index    = '0;
                    n_byte_index   = '0;
                    n_shift        = '0;
                    n_phase        = PH_CMD;
                end
            end
            PH_CMD: begin
                n_half = !r_half;
                if (r_half) begin
                    if (r_bit_index == 3'd7) begin
                        n_bit_index  = '0;
                        n_byte_index = '0;
                        n_phase      = PH_DATA;
                        n_shift      = (r_held_opcode == OP_READ) ? 8'd0 :
                                       r_held_bcd[8*(r_burst ? 3'd0 : single_lane) +: 8];
                    end else begin
                        n_bit_index = r_bit_index + 3'd1;
                    end
                end
            end
            PH_DATA: begin
                n_half = !r_half;
                if (!r_half && r_held_opcode == OP_READ) begin
                    n_shift[r_bit_index] = r_shift[r_bit_index] | i_item.io_in;
                end
                if (r_half) begin
                    if (r_bit_index == 3'd7) begin
                        n_bit_index = '0;
                        if (r_held_opcode == OP_READ) begin
                            n_read_buffer[8*cur_lane +: 8] = from_bcd(r_shift);
                        end
                        n_byte_index = next_byte;
                        if (next_byte >= byte_count) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_shift = (r_held_opcode == OP_READ) ? 8'd0 :
                                      r_held_bcd[8*next_lane +: 8];
                        end
                    end else begin
                        n_bit_index = r_bit_index + 3'd1;
                    end
                end
            end
            PH_DONE: begin
                n_phase      = PH_IDLE;
                n_half       = 1'b0;
                n_bit_index  = '0;
                n_byte_index = '0;
            end
            default: ;
        endcase
    end

    // pin levels for this tick
    always_comb begin
        pins.chip_enable  = 1'b0;
        pins.serial_clock = 1'b0;
        pins.io_out       = 1'b0;
        pins.io_drive     = 1'b1;
        pins.busy_res     = 1'b0;
        pins.done_res     = 1'b0;
        pins.read_bytes   = n_read_buffer;
        unique case (r_phase)
            PH_IDLE: begin
                pins.chip_enable = i_item.start_ok;
                pins.busy_res    = i_item.start_ok;
            end
            PH_CMD: begin
                pins.chip_enable  = 1'b1;
                pins.busy_res     = 1'b1;
                pins.serial_clock = r_half;
                pins.io_out       = r_held_command[r_bit_index];
            end
            PH_DATA: begin
                pins.chip_enable  = 1'b1;
                pins.busy_res     = 1'b1;
                pins.serial_clock = r_half;
                if (r_held_opcode == OP_READ) begin
                    pins.io_drive = 1'b0;
                end else begin
                    pins.io_out = r_shift[r_bit_index];
                end
            end
            PH_DONE: begin
                pins.done_res = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_half         <= 1'b0;
            r_bit_index    <= '0;
            r_byte_index   <= '0;
            r_shift        <= '0;
            r_held_command <= '0;
            r_held_opcode  <= OP_READ;
            r_burst        <= 1'b0;
            r_held_bcd     <= '0;
            r_read_buffer  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (fire) begin
                r_phase        <= n_phase;
                r_half         <= n_half;
                r_bit_index    <= n_bit_index;
                r_byte_index   <= n_byte_index;
                r_shift        <= n_shift;
                r_held_command <= n_held_command;
                r_held_opcode  <= n_held_opcode;
                r_burst        <= n_burst;
                r_held_bcd     <= n_held_bcd;
                r_read_buffer  <= n_read_buffer;
                r_out_valid    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= pins;
        end
    end

    a_done_ce_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.chip_enable)
        else $error("done pulse with chip enable high");

    a_busy_is_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.busy_res == r_out.chip_enable))
        else $error("busy and chip enable disagree");

    a_read_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_phase == PH_DATA && r_held_opcode == OP_READ |=> !r_out.io_drive)
        else $error("data pin driven during read data");

    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> (r_bit_index == 3'd0 && !r_half && r_byte_index == 4'd0))
        else $error("bit counters not cleared in idle");

endmodule

### rtl/core/three_wire_rtc_serial_master.sv
// three-wire rtc serial master, one input beat per half-bit tick of the link
// input channel: i_valid / o_ready, fields i_start_req, i_opcode, i_command,
//   i_write_bytes, i_io_in; every accepted beat yields exactly one result beat
// output channel: o_valid / i_ready, pin levels o_chip_enable, o_serial_clock,
//   o_io_out, o_io_drive, status o_busy_res, o_done_res and o_read_bytes
// config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index selects
//   burst read command, burst write command or protect command; write only
//   while no beats are in flight
// the front stage checks the opcode, matches burst commands and converts write
//   bytes to bcd; a two-entry queue hands beats to the back stage, which runs
//   the link sequencer one tick per beat and holds the result in a register
// an accepted beat is written into the queue, and the back stage moves it into
//   the result register, where o_valid marks it, once that register is free
// throughput: one beat per cycle while the receiver keeps i_ready high
// when i_ready is low the result register holds, the queue fills and o_ready
//   then drops until the receiver takes a result
// reset clears the sequencer to idle, the read buffer to zero, the config
//   registers to their defaults and empties the queue
module three_wire_rtc_serial_master #(
    parameter int BURST_BYTES = twrtc_pkg::BURST_BYTES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_start_req,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_command,
    input  logic [63:0] i_write_bytes,
    input  logic        i_io_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_chip_enable,
    output logic        o_serial_clock,
    output logic        o_io_out,
    output logic        o_io_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [63:0] o_read_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import twrtc_pkg::*;

    t_item   front_item;
    t_item   queue_item;
    t_result result;
    logic    q_not_full;
    logic    q_not_empty;
    logic    q_pop;

    assign o_ready = q_not_full;

    twrtc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start_req   (i_start_req),
        .i_opcode      (i_opcode),
        .i_command     (i_command),
        .i_write_bytes (i_write_bytes),
        .i_io_in       (i_io_in),
        .o_item        (front_item)
    );

    twrtc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_valid && q_not_full),
        .i_item      (front_item),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_item      (queue_item)
    );

    twrtc_back #(
        .BURST_BYTES (BURST_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_not_empty),
        .i_item       (queue_item),
        .o_item_pop   (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (result)
    );

    assign o_chip_enable  = result.chip_enable;
    assign o_serial_clock = result.serial_clock;
    assign o_io_out       = result.io_out;
    assign o_io_drive     = result.io_drive;
    assign o_busy_res     = result.busy_res;
    assign o_done_res     = result.done_res;
    assign o_read_bytes   = result.read_bytes;

endmodule
